/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands for the RTL that checks itself.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is held.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is held.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/lpr_pkg.sv */
// ----------------------------------------------------------------------------
// lpr_pkg
// Types and constants of the LRU page replacement tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package lpr_pkg;

    localparam int ADDR_W  = 10;
    localparam int PAGE_W  = 7;
    localparam int CFG_W   = 6;
    localparam int COUNT_W = 16;

    // page = addr / 10 = (addr * 205) >> 11, exact for every 10-bit address
    localparam int RECIP_W     = 8;
    localparam int RECIP_SHIFT = 11;
    localparam logic [RECIP_W-1:0] RECIP = 8'd205;

    localparam logic [CFG_W-1:0] FRAMES_RESET = 6'd4;

    typedef enum logic [0:0] {
        CMD_ACCESS = 1'b0,
        CMD_CLEAR  = 1'b1
    } t_cmd;

    typedef struct packed {
        t_cmd              command;
        logic [ADDR_W-1:0] address;
    } t_in_item;

    typedef struct packed {
        logic               hit;
        logic [PAGE_W-1:0]  page;
        logic               evicted_valid;
        logic [PAGE_W-1:0]  evicted_page;
        logic [COUNT_W-1:0] miss_count;
        logic [COUNT_W-1:0] access_count;
    } t_out_item;

    // classified work handed from front to back
    typedef struct packed {
        t_cmd              command;
        logic [PAGE_W-1:0] page;
    } t_work;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    function automatic logic [PAGE_W-1:0] page_of(input logic [ADDR_W-1:0] addr);
        logic [ADDR_W+RECIP_W-1:0] prod;
        prod = {{RECIP_W{1'b0}}, addr} * {{ADDR_W{1'b0}}, RECIP};
        return prod[RECIP_SHIFT +: PAGE_W];
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/lpr_front.sv */
// ----------------------------------------------------------------------------
// lpr_front
// Input stage: takes a beat, forms the page number and holds it for the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module lpr_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             push,
    output logic                  full,
    input  wire lpr_pkg::t_in_item i_in_item,
    output logic                  o_work_valid,
    output lpr_pkg::t_work        o_work,
    input  wire lpr_pkg::t_q_stat i_q_stat
);
    import lpr_pkg::*;

    logic  r_valid;
    logic  n_valid;
    t_work r_work;
    logic  fwd;
    logic  take;

    assign fwd  = r_valid && !i_q_stat.full;
    assign full = r_valid && i_q_stat.full;
    assign take = push && !full;

    always_comb begin
        n_valid = r_valid;
        if (fwd) begin
            n_valid = 1'b0;
        end
        if (take) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_work.command <= i_in_item.command;
            r_work.page    <= page_of(i_in_item.address);
        end
    end

    assign o_work_valid = fwd;
    assign o_work       = r_work;

endmodule

`default_nettype wire

/* hw/rtl/lpr_queue.sv */
// ----------------------------------------------------------------------------
// lpr_queue
// Two-entry queue of classified work between the front and back stages.
// ----------------------------------------------------------------------------
`default_nettype none

module lpr_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire lpr_pkg::t_work i_work,
    input  wire logic           i_pop,
    output lpr_pkg::t_work      o_work,
    output lpr_pkg::t_q_stat    o_stat
);
    import lpr_pkg::*;

    t_work      r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic       n_wr;
    logic       n_rd;
    logic [1:0] n_cnt;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = ~r_wr;
        end
        if (i_pop) begin
            n_rd = ~r_rd;
        end
        case ({i_push, i_pop})
            2'b10:   n_cnt = r_cnt + 2'd1;
            2'b01:   n_cnt = r_cnt - 2'd1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_work;
        end
    end

    assign o_work       = r_mem[r_rd];
    assign o_stat.full  = r_cnt[1];
    assign o_stat.empty = (r_cnt == 2'd0);

endmodule

`default_nettype wire

/* hw/rtl/lpr_back.sv */
// ----------------------------------------------------------------------------
// lpr_back
// Recency list, counters, result register; one item per cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module lpr_back #(
    parameter int MAX_FRAMES = 32
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_wr_en,
    input  wire logic [lpr_pkg::CFG_W-1:0] i_cfg_wr_data,
    input  wire lpr_pkg::t_work            i_work,
    input  wire lpr_pkg::t_q_stat          i_q_stat,
    output logic                           o_q_pop,
    output logic                           empty,
    input  wire logic                      pop,
    output lpr_pkg::t_out_item             o_out_item
);
    import lpr_pkg::*;

    localparam int CNT_W = $clog2(MAX_FRAMES + 1);
    localparam int LIM_W = CFG_W + 1;
    localparam logic [LIM_W-1:0] MAX_LIM = LIM_W'(MAX_FRAMES);
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    logic [CFG_W-1:0]      r_frames;
    logic [CNT_W-1:0]      r_cnt;
    logic [CNT_W-1:0]      n_cnt;
    logic [COUNT_W-1:0]    r_miss;
    logic [COUNT_W-1:0]    n_miss;
    logic [COUNT_W-1:0]    r_acc;
    logic [COUNT_W-1:0]    n_acc;
    logic                  r_out_valid;
    logic                  n_out_valid;
    t_out_item             r_out;
    t_out_item             n_out;
    logic [PAGE_W-1:0]     r_list [MAX_FRAMES];
    logic [PAGE_W-1:0]     n_list [MAX_FRAMES];
    logic [PAGE_W-1:0]     shifted [MAX_FRAMES];
    logic [MAX_FRAMES-1:0] match;
    logic [MAX_FRAMES-1:0] at_or_above;
    logic [LIM_W-1:0]      lim;
    logic                  take;
    logic                  is_access;
    logic                  found;
    logic                  evict;
    logic                  drop;
    logic [CNT_W-1:0]      cnt_d;

    assign take      = !i_q_stat.empty && (!r_out_valid || pop);
    assign is_access = (i_work.command == CMD_ACCESS);
    assign o_q_pop   = take;

    // zero frames acts as one, more than the list holds acts as the list size
    always_comb begin
        lim = {1'b0, r_frames};
        if (r_frames == '0) begin
            lim = LIM_W'(1);
        end else if (lim > MAX_LIM) begin
            lim = MAX_LIM;
        end
    end

    // parallel compare; resident pages are unique so at most one cell hits
    always_comb begin
        for (int i = 0; i < MAX_FRAMES; i++) begin
            match[i] = (CNT_W'(i) < r_cnt) && (r_list[i] == i_work.page);
        end
    end

    assign found = |match;
    assign evict = !found && (LIM_W'(r_cnt) >= lim);
    assign drop  = found || evict;
    assign cnt_d = r_cnt - CNT_W'(drop);

    // a cell at or above the removed entry takes its upper neighbor
    always_comb begin
        for (int i = 0; i < MAX_FRAMES; i++) begin
            at_or_above[i] = evict ||
                ((match & ({MAX_FRAMES{1'b1}} >> (MAX_FRAMES - 1 - i))) != '0);
        end
    end

    for (genvar g = 0; g < MAX_FRAMES; g++) begin : g_cell
        if (g < MAX_FRAMES - 1) begin : g_mid
            assign shifted[g] = r_list[g + 1];
        end else begin : g_top
            assign shifted[g] = r_list[g];
        end

        always_comb begin
            n_list[g] = r_list[g];
            if (drop && at_or_above[g]) begin
                n_list[g] = shifted[g];
            end
            if (CNT_W'(g) == cnt_d) begin
                n_list[g] = i_work.page;
            end
        end

        always_ff @(posedge i_clk) begin
            if (take && is_access) begin
                r_list[g] <= n_list[g];
            end
        end
    end

    always_comb begin
        n_cnt       = r_cnt;
        n_miss      = r_miss;
        n_acc       = r_acc;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        if (pop && r_out_valid) begin
            n_out_valid = 1'b0;
        end
        if (take) begin
            n_out_valid = 1'b1;
            if (is_access) begin
                n_cnt = drop ? r_cnt : r_cnt + CNT_W'(1);
                if (!found && r_miss != COUNT_MAX) begin
                    n_miss = r_miss + COUNT_W'(1);
                end
                if (r_acc != COUNT_MAX) begin
                    n_acc = r_acc + COUNT_W'(1);
                end
                n_out.hit           = found;
                n_out.page          = i_work.page;
                n_out.evicted_valid = evict;
                n_out.evicted_page  = evict ? r_list[0] : '0;
                n_out.miss_count    = n_miss;
                n_out.access_count  = n_acc;
            end else begin
                n_cnt  = '0;
                n_miss = '0;
                n_acc  = '0;
                n_out  = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames    <= FRAMES_RESET;
            r_cnt       <= '0;
            r_miss      <= '0;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_frames <= i_cfg_wr_data;
            end
            r_cnt       <= n_cnt;
            r_miss      <= n_miss;
            r_acc       <= n_acc;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign empty      = !r_out_valid;
    assign o_out_item = r_out;

endmodule

`default_nettype wire

/* hw/rtl/lru_page_replacement.sv */
// ----------------------------------------------------------------------------
// lru_page_replacement
// Fully associative LRU page-frame tracker with miss and access counters.
// ----------------------------------------------------------------------------
// channel   | ports                        | beat taken when
// ----------+------------------------------+-----------------------
// input     | push, full, i_in_item        | push && !full
// result    | pop, empty, o_out_item       | pop && !empty
// config    | i_cfg_wr_en, i_cfg_wr_data   | i_cfg_wr_en
//
// One beat per cycle sustained while results are popped; an item passes the
// front register, queue and result register. The back stage compares the page
// against every list cell at once and shifts the list in the same cycle.
// Reset gives an empty list, zero counters and four frames; no clearing pass.
// A stalled result stalls the back stage; the queue and the front stage
// keep taking beats until both are full.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module lru_page_replacement #(
    parameter int MAX_FRAMES = 32
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_wr_en,
    input  wire logic [lpr_pkg::CFG_W-1:0] i_cfg_wr_data,
    input  wire logic                      push,
    output logic                           full,
    input  wire lpr_pkg::t_in_item         i_in_item,
    output logic                           empty,
    input  wire logic                      pop,
    output lpr_pkg::t_out_item             o_out_item
);
    import lpr_pkg::*;

    logic    fq_push;
    t_work   fq_work;
    t_work   qb_work;
    t_q_stat q_stat;
    logic    q_pop;

    logic    out_valid;
    logic    hit_evict;
    logic    stray_evict;
    logic    miss_ok;
    logic    q_idle;

    lpr_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_in_item    (i_in_item),
        .o_work_valid (fq_push),
        .o_work       (fq_work),
        .i_q_stat     (q_stat)
    );

    lpr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fq_push),
        .i_work  (fq_work),
        .i_pop   (q_pop),
        .o_work  (qb_work),
        .o_stat  (q_stat)
    );

    lpr_back #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_work        (qb_work),
        .i_q_stat      (q_stat),
        .o_q_pop       (q_pop),
        .empty         (empty),
        .pop           (pop),
        .o_out_item    (o_out_item)
    );

    assign out_valid   = !empty;
    assign hit_evict   = o_out_item.hit && o_out_item.evicted_valid;
    assign stray_evict = !o_out_item.evicted_valid && (o_out_item.evicted_page != '0);
    assign miss_ok     = (o_out_item.miss_count <= o_out_item.access_count);
    assign q_idle      = q_stat.empty && !fq_push;

    `ASSERT_IMPLIES(a_hit_no_evict, i_clk, i_rst_n, out_valid, !hit_evict, "hit with eviction")
    `ASSERT_IMPLIES(a_evict_zero, i_clk, i_rst_n, out_valid, !stray_evict, "stray evicted page")
    `ASSERT_IMPLIES(a_miss_le_acc, i_clk, i_rst_n, out_valid, miss_ok, "miss count above access")
    `ASSERT_NEXT(a_queue_pop_empty, i_clk, i_rst_n, q_idle, !q_pop, "pop from empty queue")

endmodule

`default_nettype wire
